/* rtl/gnta_pkg.sv */
// ----------------------------------------------------------------------------
// gnta_pkg
// Types and constants shared by the gated nearest-track association unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gnta_pkg;

   localparam int MAX_TRACKS_DEFAULT = 64;
   localparam int COORD_BITS_DEFAULT = 16;

   localparam int SLOT_W  = 6;
   localparam int POS_W   = 16;
   localparam int GATE_W  = 16;
   localparam int INDEX_W = 6;
   localparam int DIST_W  = 34;

   localparam logic [GATE_W-1:0] GATE_RESET = 16'd512;

   // request mode codes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_ASSOC = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic [SLOT_W-1:0]       track_slot;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic                    track_live;
      logic                    new_frame;
   } req_type;

   typedef struct packed {
      logic               matched;
      logic [INDEX_W-1:0] track_index;
      logic [DIST_W-1:0]  dist_sq;
   } rsp_type;

   // broadcast controls for every cell of the ring
   typedef struct packed {
      logic shift;
      logic clear_taken;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

/* rtl/gnta_cell.sv */
// ----------------------------------------------------------------------------
// gnta_cell
// One track slot of the rotating ring: centroid, live mark and taken mark.
// ----------------------------------------------------------------------------
`default_nettype none

module gnta_cell #(
   parameter int COORD_BITS = gnta_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gnta_pkg::cell_ctrl_type       ctrl,
   input  wire logic                          load_we,
   input  wire logic                          load_live,
   input  wire logic signed [COORD_BITS-1:0]  load_x,
   input  wire logic signed [COORD_BITS-1:0]  load_y,
   input  wire logic signed [COORD_BITS-1:0]  load_z,
   input  wire logic                          set_taken,
   input  wire logic                          nb_live,
   input  wire logic                          nb_taken,
   input  wire logic signed [COORD_BITS-1:0]  nb_x,
   input  wire logic signed [COORD_BITS-1:0]  nb_y,
   input  wire logic signed [COORD_BITS-1:0]  nb_z,
   output logic                               live,
   output logic                               taken,
   output logic signed [COORD_BITS-1:0]       x,
   output logic signed [COORD_BITS-1:0]       y,
   output logic signed [COORD_BITS-1:0]       z
);

   logic                         live_ff,  live_in;
   logic                         taken_ff, taken_in;
   logic signed [COORD_BITS-1:0] x_ff, x_in;
   logic signed [COORD_BITS-1:0] y_ff, y_in;
   logic signed [COORD_BITS-1:0] z_ff, z_in;

   always_comb begin
      live_in  = live_ff;
      taken_in = taken_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      priority if (ctrl.shift) begin
         live_in = nb_live;
         x_in    = nb_x;
         y_in    = nb_y;
         z_in    = nb_z;
      end else if (load_we) begin
         live_in = load_live;
         x_in    = load_x;
         y_in    = load_y;
         z_in    = load_z;
      end else begin
         live_in = live_ff;
         x_in    = x_ff;
         y_in    = y_ff;
         z_in    = z_ff;
      end
      priority if (ctrl.clear_taken) begin
         taken_in = 1'b0;
      end else if (ctrl.shift) begin
         taken_in = nb_taken;
      end else if (set_taken) begin
         taken_in = 1'b1;
      end else begin
         taken_in = taken_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= 1'b0;
         taken_ff <= 1'b0;
      end else begin
         live_ff  <= live_in;
         taken_ff <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign live  = live_ff;
   assign taken = taken_ff;
   assign x     = x_ff;
   assign y     = y_ff;
   assign z     = z_ff;

endmodule

`default_nettype wire

/* rtl/gnta_dist.sv */
// ----------------------------------------------------------------------------
// gnta_dist
// Three-stage squared-distance pipeline fed by the head cell of the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module gnta_dist #(
   parameter int COORD_BITS = gnta_pkg::COORD_BITS_DEFAULT,
   parameter int IDX_W      = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic                          in_last,
   input  wire logic                          in_cand,
   input  wire logic [IDX_W-1:0]              in_idx,
   input  wire logic signed [COORD_BITS-1:0]  trk_x,
   input  wire logic signed [COORD_BITS-1:0]  trk_y,
   input  wire logic signed [COORD_BITS-1:0]  trk_z,
   input  wire logic signed [COORD_BITS-1:0]  qry_x,
   input  wire logic signed [COORD_BITS-1:0]  qry_y,
   input  wire logic signed [COORD_BITS-1:0]  qry_z,
   output logic                               out_valid,
   output logic                               out_last,
   output logic                               out_cand,
   output logic [IDX_W-1:0]                   out_idx,
   output logic [2*COORD_BITS+1:0]            out_dist
);

   localparam int AW = COORD_BITS + 1;
   localparam int DW = 2 * COORD_BITS + 2;

   logic signed [AW-1:0] dx, dy, dz;
   logic [AW-1:0]        ax_in, ay_in, az_in;
   logic [AW-1:0]        ax_ff, ay_ff, az_ff;
   logic [DW-1:0]        sx_in, sy_in, sz_in;
   logic [DW-1:0]        sx_ff, sy_ff, sz_ff;
   logic [DW-1:0]        sum_in, sum_ff;

   logic [2:0]           valid_ff;
   logic [2:0]           last_ff;
   logic                 cand1_ff, cand2_ff, cand3_ff;
   logic [IDX_W-1:0]     idx1_ff, idx2_ff, idx3_ff;

   assign dx = AW'(trk_x) - AW'(qry_x);
   assign dy = AW'(trk_y) - AW'(qry_y);
   assign dz = AW'(trk_z) - AW'(qry_z);

   assign ax_in = dx[AW-1] ? AW'(-dx) : AW'(dx);
   assign ay_in = dy[AW-1] ? AW'(-dy) : AW'(dy);
   assign az_in = dz[AW-1] ? AW'(-dz) : AW'(dz);

   assign sx_in = DW'(ax_ff) * DW'(ax_ff);
   assign sy_in = DW'(ay_ff) * DW'(ay_ff);
   assign sz_in = DW'(az_ff) * DW'(az_ff);

   // three squares of AW bits each: the sum cannot overflow DW bits
   assign sum_in = sx_ff + sy_ff + sz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         last_ff  <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
         last_ff  <= {last_ff[1:0], in_valid & in_last};
      end
   end

   always_ff @(posedge clock) begin
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      az_ff    <= az_in;
      cand1_ff <= in_cand;
      idx1_ff  <= in_idx;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      sz_ff    <= sz_in;
      cand2_ff <= cand1_ff;
      idx2_ff  <= idx1_ff;
      sum_ff   <= sum_in;
      cand3_ff <= cand2_ff;
      idx3_ff  <= idx2_ff;
   end

   assign out_valid = valid_ff[2];
   assign out_last  = last_ff[2];
   assign out_cand  = cand3_ff;
   assign out_idx   = idx3_ff;
   assign out_dist  = sum_ff;

endmodule

`default_nettype wire

/* rtl/gated_nearest_track_association_unit.sv */
// ----------------------------------------------------------------------------
// gated_nearest_track_association_unit
// Greedy gated nearest-neighbor association of cluster centroids to tracks.
// ----------------------------------------------------------------------------
// The track table lives in a ring of MAX_TRACKS cells. A load transaction
// writes one cell and gives no response. An associate transaction rotates
// the ring once around, one cell per cycle, past a single three-stage
// squared-distance unit at the head, then drains that pipeline and posts
// the response; no new request is taken before that response is posted.
// The ring rotation through the one distance unit sets the request pace.
// A pending response does not block the next request; only posting a new
// one waits. csr_data sets the gate distance; the user must write it only
// while no transaction is busy, as the block itself does not enforce this.
`default_nettype none

module gated_nearest_track_association_unit #(
   parameter int MAX_TRACKS = gnta_pkg::MAX_TRACKS_DEFAULT,
   parameter int COORD_BITS = gnta_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire gnta_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output gnta_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [gnta_pkg::GATE_W-1:0]  csr_data
);

   localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int DW = 2 * COORD_BITS + 2;
   localparam int CW = (DW > 32) ? DW : 32;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TRACKS - 1);

   gnta_pkg::state_type state_ff, state_in;

   logic [gnta_pkg::GATE_W-1:0] gate_ff;
   logic [31:0]                 gate_sq_ff;
   logic [31:0]                 gate_sq_in;

   logic [IW-1:0] cnt_ff, cnt_in;

   logic signed [COORD_BITS-1:0] qx_ff, qy_ff, qz_ff;
   logic signed [COORD_BITS-1:0] in_x, in_y, in_z;

   logic          found_ff;
   logic [IW-1:0] best_idx_ff;
   logic [DW-1:0] best_d_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   gnta_pkg::rsp_type rsp_ff;

   logic accept, start_assoc, do_load, finish_fire, hit;
   gnta_pkg::cell_ctrl_type ctrl;

   logic [MAX_TRACKS-1:0]        c_live, c_taken;
   logic signed [COORD_BITS-1:0] c_x [MAX_TRACKS];
   logic signed [COORD_BITS-1:0] c_y [MAX_TRACKS];
   logic signed [COORD_BITS-1:0] c_z [MAX_TRACKS];

   logic                  d_valid, d_last, d_cand;
   logic [IW-1:0]         d_idx;
   logic [DW-1:0]         d_dist;
   logic [CW-1:0]         d_ext, gate_ext;

   logic [IW+gnta_pkg::INDEX_W-1:0] idx_wide;
   logic [DW+gnta_pkg::DIST_W-1:0]  dist_wide;

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   assign req_stall   = (state_ff != gnta_pkg::ST_IDLE);
   assign accept      = req_valid & ~req_stall;
   assign start_assoc = accept & (req_data.mode == gnta_pkg::MODE_ASSOC);
   assign do_load     = accept & (req_data.mode == gnta_pkg::MODE_LOAD);

   assign in_x = COORD_BITS'(req_data.pos_x);
   assign in_y = COORD_BITS'(req_data.pos_y);
   assign in_z = COORD_BITS'(req_data.pos_z);

   // ------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------
   assign csr_ready  = 1'b1;
   assign gate_sq_in = 32'(gate_ff) * 32'(gate_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff <= gnta_pkg::GATE_RESET;
      end else if (csr_valid) begin
         gate_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      gate_sq_ff <= gate_sq_in;
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gnta_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      ctrl.shift       = 1'b0;
      ctrl.clear_taken = 1'b0;
      finish_fire      = 1'b0;
      unique case (state_ff)
         gnta_pkg::ST_IDLE: begin
            if (start_assoc) begin
               ctrl.clear_taken = req_data.new_frame;
               cnt_in           = '0;
               state_in         = gnta_pkg::ST_SCAN;
            end
         end
         gnta_pkg::ST_SCAN: begin
            ctrl.shift = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = gnta_pkg::ST_DRAIN;
            end
         end
         gnta_pkg::ST_DRAIN: begin
            if (d_valid && d_last) begin
               state_in = gnta_pkg::ST_FINISH;
            end
         end
         gnta_pkg::ST_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               finish_fire = 1'b1;
               state_in    = gnta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gnta_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (start_assoc) begin
         qx_ff <= in_x;
         qy_ff <= in_y;
         qz_ff <= in_z;
      end
   end

   // ------------------------------------------------------------------
   // ring of track cells; cell i takes from cell i+1, the last wraps to 0
   // ------------------------------------------------------------------
   for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_cell
      localparam int NB = (i + 1) % MAX_TRACKS;
      logic load_we;
      logic set_taken;

      assign load_we   = do_load & ({26'd0, req_data.track_slot} == 32'(i));
      assign set_taken = finish_fire & found_ff & (best_idx_ff == IW'(i));

      gnta_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .load_we   (load_we),
         .load_live (req_data.track_live),
         .load_x    (in_x),
         .load_y    (in_y),
         .load_z    (in_z),
         .set_taken (set_taken),
         .nb_live   (c_live[NB]),
         .nb_taken  (c_taken[NB]),
         .nb_x      (c_x[NB]),
         .nb_y      (c_y[NB]),
         .nb_z      (c_z[NB]),
         .live      (c_live[i]),
         .taken     (c_taken[i]),
         .x         (c_x[i]),
         .y         (c_y[i]),
         .z         (c_z[i])
      );
   end

   // ------------------------------------------------------------------
   // distance unit at the head of the ring
   // ------------------------------------------------------------------
   gnta_dist #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IW)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ctrl.shift),
      .in_last   (cnt_ff == LAST_IDX),
      .in_cand   (c_live[0] & ~c_taken[0]),
      .in_idx    (cnt_ff),
      .trk_x     (c_x[0]),
      .trk_y     (c_y[0]),
      .trk_z     (c_z[0]),
      .qry_x     (qx_ff),
      .qry_y     (qy_ff),
      .qry_z     (qz_ff),
      .out_valid (d_valid),
      .out_last  (d_last),
      .out_cand  (d_cand),
      .out_idx   (d_idx),
      .out_dist  (d_dist)
   );

   assign d_ext    = CW'(d_dist);
   assign gate_ext = CW'(gate_sq_ff);
   // strict less-than keeps the lowest index on a tie
   assign hit = d_valid & d_cand & (d_ext <= gate_ext) & (~found_ff | (d_dist < best_d_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (start_assoc) begin
         found_ff <= 1'b0;
      end else if (hit) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start_assoc) begin
         best_idx_ff <= '0;
         best_d_ff   <= '0;
      end else if (hit) begin
         best_idx_ff <= d_idx;
         best_d_ff   <= d_dist;
      end
   end

   // ------------------------------------------------------------------
   // response register
   // ------------------------------------------------------------------
   assign idx_wide  = {{gnta_pkg::INDEX_W{1'b0}}, best_idx_ff};
   assign dist_wide = {{gnta_pkg::DIST_W{1'b0}}, best_d_ff};

   assign rsp_valid_in = finish_fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_fire) begin
         rsp_ff.matched     <= found_ff;
         rsp_ff.track_index <= idx_wide[gnta_pkg::INDEX_W-1:0];
         rsp_ff.dist_sq     <= dist_wide[gnta_pkg::DIST_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/gnta_checker.sv */
// ----------------------------------------------------------------------------
// gnta_checker
// Port-level checks of the association unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gnta_checker #(
   parameter int MAX_TRACKS = gnta_pkg::MAX_TRACKS_DEFAULT
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire gnta_pkg::rsp_type rsp_data
);

   // a cluster without a match reports zero index and zero distance
   a_null_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.matched |-> rsp_data.track_index == '0 && rsp_data.dist_sq == '0)
      else $error("unmatched response carries nonzero index or distance");

   // a matched index must name a slot of the table
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.matched |-> 32'(rsp_data.track_index) <= MAX_TRACKS - 1)
      else $error("matched index outside the track table");

   // a scan takes a full ring turn: no response appears right after a request
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("response posted one cycle after a request transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind gated_nearest_track_association_unit gnta_checker #(
   .MAX_TRACKS (MAX_TRACKS)
) u_gnta_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* tb/tb_gated_nearest_track_association_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gated_nearest_track_association_unit
// Self-checking bench for the gated nearest-track association unit.
// ----------------------------------------------------------------------------
// A clocked driver feeds load and associate transactions from a queue. A
// track-table model predicts the assignment for every associate transaction
// at acceptance, and a clocked monitor compares each response with the oldest
// prediction. The gate distance is rewritten between phases while the unit is
// idle. Sender and receiver idle at random, the receiver once holds off long
// enough to back the unit up, and the sender once pauses until all responses
// are back.
// ----------------------------------------------------------------------------

module tb_gated_nearest_track_association_unit;

   localparam int MAX_TRACKS     = gnta_pkg::MAX_TRACKS_DEFAULT;
   localparam int SLOT_W         = gnta_pkg::SLOT_W;
   localparam int POS_W          = gnta_pkg::POS_W;
   localparam int GATE_W         = gnta_pkg::GATE_W;
   localparam int INDEX_W        = gnta_pkg::INDEX_W;
   localparam int DIST_W         = gnta_pkg::DIST_W;
   localparam int DRAIN_CYCLES   = MAX_TRACKS + 5 + 25;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int PHASE_ITEMS    = 115;
   localparam int unsigned CYCLE_LIMIT = 600000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   gnta_pkg::req_type   req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   gnta_pkg::rsp_type   rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [GATE_W-1:0]   csr_data = '0;

   // track-table model
   logic signed [POS_W-1:0] trk_x [MAX_TRACKS];
   logic signed [POS_W-1:0] trk_y [MAX_TRACKS];
   logic signed [POS_W-1:0] trk_z [MAX_TRACKS];
   bit                      trk_live [MAX_TRACKS];
   bit                      trk_taken [MAX_TRACKS];
   int unsigned             gate_now = gnta_pkg::GATE_RESET;

   // stimulus side
   gnta_pkg::req_type request_queue [$];
   gnta_pkg::rsp_type expected_assignments [$];
   int          loaded_x [MAX_TRACKS];
   int          loaded_y [MAX_TRACKS];
   int          loaded_z [MAX_TRACKS];
   int          gate_setting = gnta_pkg::GATE_RESET;
   int          items_queued = 0;
   int          snd_idle_pct = 6;
   int          rcv_idle_pct = 75;
   int          holdoff_requests = 0;
   int          holdoff_served = 0;
   int          holdoff_left = 0;

   // statistics
   int          requests_applied = 0;
   int          assoc_applied = 0;
   int          matches_predicted = 0;
   int          responses_checked = 0;
   int          gate_writes = 0;
   int          error_count = 0;
   int unsigned cycle_count = 0;

   gated_nearest_track_association_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Update the track table with one accepted transaction and predict the
   // assignment of an associate transaction.
   task automatic apply_to_track_table(input gnta_pkg::req_type r);
      gnta_pkg::rsp_type res;
      longint  gate_sq;
      longint  dx;
      longint  dy;
      longint  dz;
      longint  d;
      longint  best_d;
      int      best;
      bit      found;
      requests_applied++;
      if (r.mode == gnta_pkg::MODE_LOAD) begin
         if (r.track_slot < MAX_TRACKS) begin
            trk_x[r.track_slot]    = r.pos_x;
            trk_y[r.track_slot]    = r.pos_y;
            trk_z[r.track_slot]    = r.pos_z;
            trk_live[r.track_slot] = r.track_live;
         end
         return;
      end
      assoc_applied++;
      if (r.new_frame) begin
         foreach (trk_taken[i]) trk_taken[i] = 1'b0;
      end
      gate_sq = longint'(gate_now) * longint'(gate_now);
      found   = 1'b0;
      best    = 0;
      best_d  = 0;
      for (int i = 0; i < MAX_TRACKS; i++) begin
         if (trk_live[i] && !trk_taken[i]) begin
            dx = longint'(trk_x[i]) - longint'($signed(r.pos_x));
            dy = longint'(trk_y[i]) - longint'($signed(r.pos_y));
            dz = longint'(trk_z[i]) - longint'($signed(r.pos_z));
            d  = dx * dx + dy * dy + dz * dz;
            // strict compare keeps the lowest slot on a tie
            if (d <= gate_sq && (!found || d < best_d)) begin
               found  = 1'b1;
               best   = i;
               best_d = d;
            end
         end
      end
      res = '0;
      if (found) begin
         trk_taken[best] = 1'b1;
         matches_predicted++;
         res.matched     = 1'b1;
         res.track_index = INDEX_W'(best);
         res.dist_sq     = DIST_W'(best_d);
      end
      expected_assignments = {expected_assignments, res};
   endtask

   task automatic queue_request(input logic mode, input int slot, input int x, input int y,
                                input int z, input logic live, input logic nf);
      gnta_pkg::req_type r;
      r.mode       = mode;
      r.track_slot = SLOT_W'(slot);
      r.pos_x      = POS_W'(x);
      r.pos_y      = POS_W'(y);
      r.pos_z      = POS_W'(z);
      r.track_live = live;
      r.new_frame  = nf;
      if (mode == gnta_pkg::MODE_LOAD) begin
         loaded_x[r.track_slot] = int'($signed(r.pos_x));
         loaded_y[r.track_slot] = int'($signed(r.pos_y));
         loaded_z[r.track_slot] = int'($signed(r.pos_z));
      end
      request_queue = {request_queue, r};
      items_queued++;
   endtask

   function automatic int jitter(input int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   // One frame: a few track loads around a common center, then clusters that
   // mostly land near those tracks. Now and then some noise goes in first.
   task automatic queue_frame();
      int slots [$];
      int cx;
      int cy;
      int cz;
      int s;
      int g;
      int pick;
      int n_assoc;
      logic nf;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 4)) begin
            queue_request($urandom_range(1), $urandom_range(63), $urandom, $urandom,
                          $urandom, $urandom_range(1), $urandom_range(1));
         end
      end
      cx = jitter(20000);
      cy = jitter(20000);
      cz = jitter(20000);
      repeat ($urandom_range(1, 10)) begin
         s = $urandom_range(63);
         if ($urandom_range(99) < 10) begin
            queue_request(gnta_pkg::MODE_LOAD, s, $urandom, $urandom, $urandom,
                          $urandom_range(99) < 85, $urandom_range(1));
         end else begin
            queue_request(gnta_pkg::MODE_LOAD, s, cx + jitter(600), cy + jitter(600),
                          cz + jitter(600), $urandom_range(99) < 85, $urandom_range(1));
         end
         slots = {slots, s};
      end
      g = gate_setting / 2;
      n_assoc = int'($urandom_range(1, 6));
      for (int k = 0; k < n_assoc; k++) begin
         nf   = (k == 0) ? ($urandom_range(99) < 90) : ($urandom_range(99) < 10);
         s    = slots[$urandom_range(slots.size() - 1)];
         pick = $urandom_range(99);
         if (pick < 15) begin
            queue_request(gnta_pkg::MODE_ASSOC, $urandom_range(63), $urandom, $urandom,
                          $urandom, $urandom_range(1), nf);
         end else if (pick < 27) begin
            queue_request(gnta_pkg::MODE_ASSOC, $urandom_range(63), loaded_x[s], loaded_y[s],
                          loaded_z[s], $urandom_range(1), nf);
         end else if (pick < 33) begin
            // on the gate or one step outside it
            queue_request(gnta_pkg::MODE_ASSOC, $urandom_range(63),
                          loaded_x[s] + gate_setting + int'($urandom_range(1)),
                          loaded_y[s], loaded_z[s], $urandom_range(1), nf);
         end else begin
            queue_request(gnta_pkg::MODE_ASSOC, $urandom_range(63), loaded_x[s] + jitter(g),
                          loaded_y[s] + jitter(g), loaded_z[s] + jitter(g),
                          $urandom_range(1), nf);
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (request_queue.size() != 0 || req_valid || expected_assignments.size() != 0);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_to_track_table(req_data);
         end
         // hold a stalled transaction, otherwise offer the next one or idle
         if (!req_valid || !req_stall) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
               req_data  <= request_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (holdoff_served != holdoff_requests) begin
         holdoff_served = holdoff_requests;
         holdoff_left   = HOLDOFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      gnta_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_assignments.size() == 0) begin
            $error("response with no association pending: matched %0d index %0d dist_sq %0d",
                   rsp_data.matched, rsp_data.track_index, rsp_data.dist_sq);
            error_count++;
         end else begin
            want = expected_assignments.pop_front();
            responses_checked++;
            if (rsp_data.matched !== want.matched) begin
               $error("matched: expected %0d, actual %0d", want.matched, rsp_data.matched);
               error_count++;
            end
            if (rsp_data.track_index !== want.track_index) begin
               $error("track_index: expected %0d, actual %0d",
                      want.track_index, rsp_data.track_index);
               error_count++;
            end
            if (rsp_data.dist_sq !== want.dist_sq) begin
               $error("dist_sq: expected %0d, actual %0d", want.dist_sq, rsp_data.dist_sq);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("cycle limit reached with %0d transactions queued and %0d responses pending",
                request_queue.size(), expected_assignments.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int gate_list [6];
      int half_mark;
      int phase_end;
      gate_list = '{0, 65535, 512, 1 + $urandom_range(2999), 100, $urandom_range(65535)};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed transactions at the reset gate of 512
      queue_request(gnta_pkg::MODE_LOAD, 0, 0, 0, 0, 1'b1, 1'b0);
      queue_request(gnta_pkg::MODE_LOAD, 63, 0, 0, 0, 1'b1, 1'b1);
      queue_request(gnta_pkg::MODE_ASSOC, 63, 0, 0, 0, 1'b1, 1'b1);
      queue_request(gnta_pkg::MODE_ASSOC, 0, 0, 0, 0, 1'b0, 1'b0);
      queue_request(gnta_pkg::MODE_ASSOC, 0, 0, 0, 0, 1'b0, 1'b0);
      queue_request(gnta_pkg::MODE_ASSOC, 0, 512, 0, 0, 1'b0, 1'b1);
      queue_request(gnta_pkg::MODE_ASSOC, 0, 0, -513, 0, 1'b0, 1'b1);
      queue_request(gnta_pkg::MODE_LOAD, 5, 100, 0, 0, 1'b0, 1'b0);
      queue_request(gnta_pkg::MODE_ASSOC, 5, 100, 0, 0, 1'b1, 1'b1);
      queue_request(gnta_pkg::MODE_LOAD, 1, 32767, 32767, 32767, 1'b1, 1'b1);
      queue_request(gnta_pkg::MODE_LOAD, 2, -32768, -32768, -32768, 1'b1, 1'b0);
      queue_request(gnta_pkg::MODE_ASSOC, 63, -32768, -32768, -32768, 1'b0, 1'b0);
      queue_request(gnta_pkg::MODE_ASSOC, 0, 32767, 32767, 32767, 1'b0, 1'b0);
      queue_request(gnta_pkg::MODE_LOAD, 1, 32767, 32767, 32767, 1'b1, 1'b0);
      queue_request(gnta_pkg::MODE_ASSOC, 0, 32767, 32767, 32767, 1'b0, 1'b0);
      queue_request(gnta_pkg::MODE_ASSOC, 0, 0, 0, 32767, 1'b0, 1'b1);
      queue_request(gnta_pkg::MODE_ASSOC, 0, 32767, 32767, 32767, 1'b0, 1'b1);

      for (int p = 0; p < 6; p++) begin
         // loads give no response, so let the unit settle before the write
         wait_drained();
         repeat (DRAIN_CYCLES) @(posedge clock);
         gate_setting = gate_list[p];
         csr_valid <= 1'b1;
         csr_data  <= GATE_W'(gate_setting);
         do @(posedge clock);
         while (!csr_ready);
         csr_valid <= 1'b0;
         gate_now = gate_setting;
         gate_writes++;
         @(negedge clock);

         snd_idle_pct = (p < 2) ? 6 : (p < 4) ? 75 : 0;
         rcv_idle_pct = (p < 2) ? 75 : (p < 4) ? 6 : 0;
         half_mark = items_queued + PHASE_ITEMS / 2;
         phase_end = items_queued + PHASE_ITEMS;
         while (items_queued < half_mark) queue_frame();
         if (p == 2) begin
            wait_drained();
         end
         if (p == 4) begin
            holdoff_requests++;
         end
         while (items_queued < phase_end) queue_frame();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_assignments.size() != 0) begin
         $error("%0d predicted assignments never arrived", expected_assignments.size());
         error_count++;
      end
      $display("Applied %0d transactions (%0d associations, %0d predicted matches) under %0d",
               requests_applied, assoc_applied, matches_predicted, gate_writes + 1);
      $display("gate settings; %0d responses checked field by field", responses_checked);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/gnta_pkg.sv
rtl/gnta_cell.sv
rtl/gnta_dist.sv
rtl/gated_nearest_track_association_unit.sv
rtl/gnta_checker.sv
tb/tb_gated_nearest_track_association_unit.sv
